// ===== design/itc_pkg.sv =====
`timescale 1ns / 1ps
// itc_pkg: shared types and constants of the index topology converter.
// No dependencies; imported by every module of the block.
package itc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_INDEX_WIDE = 2'd1;
  localparam logic [1:0] REG_CAPACITY   = 2'd2;

  // Conversion modes (code 3 takes indices and emits only a zero summary at list end)
  localparam logic [1:0] MODE_STRIP = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_FLIP  = 2'd2;

  // Result kinds
  localparam logic KIND_INDEX   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int unsigned IDX_W     = 32;
  localparam int unsigned FIELD_W   = 24;
  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] CAPACITY_RESET = {FIELD_W{1'b1}};

  // Job queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = 1;

  // Indices held in the window
  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_TWO
  } phase_t;

  // One accepted index turned into the beats it causes
  typedef struct packed {
    logic [1:0]                        n_idx;     // index beats: 0, 2 or 3
    logic [2:0][IDX_W-1:0]             v;         // indices, beat order
    logic [2:0][FIELD_W-1:0]           c;         // written count per index beat
    logic                              summ;      // end-of-list summary follows
    logic [FIELD_W-1:0]                sum_count; // count carried by the summary
  } job_t;

endpackage

// ===== design/itc_front.sv =====
`timescale 1ns / 1ps
// itc_front: config registers, index window and counters; turns each input
// beat into a job for the queue. Depends on itc_pkg.
module itc_front import itc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [FIELD_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   in_index,
  input  logic               in_last,
  output logic               job_valid,
  input  logic               job_ready,
  output job_t               job
);

  localparam int unsigned CMPW = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [1:0]             mode;
  logic                   index_wide;
  logic [FIELD_W-1:0]     capacity;

  logic [IDX_W-1:0]       older_index, older_index_next;
  logic [IDX_W-1:0]       newer_index, newer_index_next;
  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] written_count, written_count_next;
  logic [COUNT_WIDTH-1:0] received_count, received_count_next;

  logic [IDX_W-1:0]       idx;
  logic [1:0]             prim_k;
  logic [2:0][IDX_W-1:0]  prim_v;
  logic                   room;
  logic [COUNT_WIDTH-1:0] wc_upd;
  logic [COUNT_WIDTH-1:0] rc_inc;
  logic [COUNT_WIDTH-1:0] sum_raw;
  logic                   accept;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(
    input logic [COUNT_WIDTH-1:0] a,
    input logic [1:0]             k
  );
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {{(COUNT_WIDTH - 1){1'b0}}, k};
    return s[COUNT_WIDTH] ? CNT_MAX : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] clip(input logic [COUNT_WIDTH-1:0] a);
    logic [CMPW-1:0] e;
    e = CMPW'(a);
    return (e > CMPW'(FIELD_MAX)) ? FIELD_MAX : e[FIELD_W-1:0];
  endfunction

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign idx      = index_wide ? in_index : {16'h0000, in_index[15:0]};
  assign rc_inc   = sat_add(received_count, 2'd1);

  // Window phase
  always_comb begin
    if (in_last) begin
      phase_next = PH_EMPTY;
    end else if (phase == PH_EMPTY) begin
      phase_next = PH_ONE;
    end else if (mode == MODE_LINE) begin
      phase_next = phase;
    end else if (phase == PH_ONE) begin
      phase_next = PH_TWO;
    end else if (mode == MODE_STRIP) begin
      phase_next = phase;
    end else begin
      phase_next = PH_EMPTY;
    end
  end

  // Window update and primitive selection
  always_comb begin
    older_index_next = older_index;
    newer_index_next = newer_index;
    prim_k           = 2'd0;
    prim_v           = {older_index, idx, older_index};
    if (phase == PH_EMPTY) begin
      older_index_next = idx;
    end else if (mode == MODE_LINE) begin
      if (older_index != idx) begin
        prim_k           = 2'd2;
        prim_v           = {older_index, idx, older_index};
        older_index_next = idx;
      end
    end else if (phase == PH_ONE) begin
      newer_index_next = idx;
    end else if (mode == MODE_STRIP) begin
      if (older_index != newer_index && newer_index != idx) begin
        prim_k = 2'd3;
        prim_v = {idx, newer_index, older_index};
      end
      older_index_next = newer_index;
      newer_index_next = idx;
    end else if (mode == MODE_FLIP) begin
      prim_k = 2'd3;
      prim_v = {newer_index, idx, older_index};
    end
  end

  // Capacity gate, counts and job assembly
  always_comb begin
    room      = CMPW'(written_count) < CMPW'(capacity);
    job.n_idx = (room) ? prim_k : 2'd0;
    job.v     = prim_v;
    job.c[0]  = clip(sat_add(written_count, 2'd1));
    job.c[1]  = clip(sat_add(written_count, 2'd2));
    job.c[2]  = clip(sat_add(written_count, 2'd3));
    wc_upd    = (job.n_idx != 2'd0) ? sat_add(written_count, job.n_idx) : written_count;
    case (mode)
      MODE_FLIP:  sum_raw = rc_inc;
      MODE_STRIP: sum_raw = wc_upd;
      MODE_LINE:  sum_raw = wc_upd;
      default:    sum_raw = '0;
    endcase
    job.summ            = in_last;
    job.sum_count       = clip(sum_raw);
    written_count_next  = in_last ? '0 : wc_upd;
    received_count_next = in_last ? '0 : rc_inc;
    job_valid           = in_valid && ((job.n_idx != 2'd0) || in_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_STRIP;
      index_wide <= 1'b0;
      capacity   <= CAPACITY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:       mode       <= cfg_data[1:0];
        REG_INDEX_WIDE: index_wide <= cfg_data[0];
        REG_CAPACITY:   capacity   <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_index    <= '0;
      newer_index    <= '0;
      phase          <= PH_EMPTY;
      written_count  <= '0;
      received_count <= '0;
    end else if (accept) begin
      older_index    <= older_index_next;
      newer_index    <= newer_index_next;
      phase          <= phase_next;
      written_count  <= written_count_next;
      received_count <= received_count_next;
    end
  end

endmodule

// ===== design/itc_job_fifo.sv =====
`timescale 1ns / 1ps
// itc_job_fifo: two-entry register queue of jobs between front and back.
// Depends on itc_pkg.
module itc_job_fifo import itc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_data
);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = fill != (FIFO_AW + 1)'(FIFO_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/itc_back.sv =====
`timescale 1ns / 1ps
// itc_back: walks the job at the queue head one beat at a time into the
// output register. Depends on itc_pkg.
module itc_back import itc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_pop,
  input  job_t               job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [IDX_W-1:0]   out_index,
  output logic [FIELD_W-1:0] out_count,
  output logic               out_run_end
);

  logic [1:0]         pos;
  logic [2:0]         total;
  logic               is_idx;
  logic               last_beat;
  logic               load;
  logic [IDX_W-1:0]   beat_index;
  logic [FIELD_W-1:0] beat_count;

  assign total     = {1'b0, job.n_idx} + {2'b00, job.summ};
  assign is_idx    = pos < job.n_idx;
  assign last_beat = ({1'b0, pos} + 3'd1) == total;
  assign load      = job_valid && (!out_valid || out_ready);
  assign job_pop   = load && last_beat;

  always_comb begin
    case (pos)
      2'd0:    begin beat_index = job.v[0]; beat_count = job.c[0]; end
      2'd1:    begin beat_index = job.v[1]; beat_count = job.c[1]; end
      2'd2:    begin beat_index = job.v[2]; beat_count = job.c[2]; end
      default: begin beat_index = '0;       beat_count = job.sum_count; end
    endcase
    if (!is_idx) begin
      beat_index = '0;
      beat_count = job.sum_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pos       <= last_beat ? 2'd0 : pos + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind    <= is_idx ? KIND_INDEX : KIND_SUMMARY;
      out_index   <= beat_index;
      out_count   <= beat_count;
      out_run_end <= last_beat;
    end
  end

endmodule

// ===== design/index_topology_converter_unit.sv =====
`timescale 1ns / 1ps
// index_topology_converter_unit: strip/list index conversion, top level.
// A result beat passes through the job queue and then the output register
// before it shows on the master side.
// Throughput: one input beat per cycle while the two-entry job queue has room;
// one result beat per cycle from the single output register while the master side
// is ready, so an index that closes a triangle gives three beats, four with the summary.
// Reset: synchronous; config returns to mode 0, 16-bit indices, full capacity,
// window and counts clear, queue and output register empty.
module index_topology_converter_unit import itc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  // input index stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] index
  input  logic         s_axis_tlast,   // last index of the list
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,   // [31:0] index_out, [55:32] count
  output logic         m_axis_tuser,   // [0] kind: 0 index, 1 summary
  output logic         m_axis_tlast    // run_end: last beat caused by the input
);

  job_t               push_job;
  logic               push_valid;
  logic               push_ready;
  job_t               head_job;
  logic               head_valid;
  logic               head_pop;
  logic [IDX_W-1:0]   res_index;
  logic [FIELD_W-1:0] res_count;

  // Config writes are taken on any cycle; the front owns the registers.
  assign cfg_ready = 1'b1;

  // Front: config, sliding window, counters, capacity gate.
  itc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_index  (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  // Jobs carry up to three indices plus the optional summary.
  itc_job_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_data   (head_job)
  );

  // Back: one result beat per cycle into the output register while the master side is ready.
  itc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (head_valid),
    .job_pop     (head_pop),
    .job         (head_job),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_index   (res_index),
    .out_count   (res_count),
    .out_run_end (m_axis_tlast)
  );

  assign m_axis_tdata = {res_count, res_index};

endmodule

// ===== tb/index_topology_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// index_topology_converter_unit_tb: self-checking bench for the strip/list converter.
// Depends on itc_pkg and index_topology_converter_unit; drives a directed table,
// then random index lists under several idle/stall mixes, checked beat by beat.
module index_topology_converter_unit_tb;
  import itc_pkg::*;

  localparam int unsigned COUNT_W = 24;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;
  // Mode code 3 has no name in the package: indices taken, only a zero summary emitted
  localparam logic [1:0] MODE_IDLE = 2'd3;
  // Result beat trails its input beat through a two-deep job queue and the output register
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES = 4;
  localparam int ITEMS_PER_PHASE = 18;

  // One result beat as seen on the master side
  typedef struct packed {
    logic              kind;
    logic [31:0]       index_out;
    logic [FIELD_W-1:0] count;
    logic              run_end;
  } beat_t;

  typedef enum logic {ROW_INDEX, ROW_WRITE} row_op_t;

  // Directed row: an index beat or a register write. Pinned rows carry a
  // summary count typed in by hand; their only result is that summary.
  typedef struct {
    row_op_t           op;
    logic [1:0]        reg_sel;
    logic [23:0]       reg_val;
    logic [31:0]       index;
    logic              last;
    logic              pinned;
    logic [23:0]       pinned_count;
  } plan_row_t;

  localparam int PLAN_LEN = 33;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = REG_MODE;
  logic [23:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;    // [31:0] index
  logic         s_axis_tlast = 1'b0;  // last index of the list
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;         // [31:0] index_out, [55:32] count
  logic         m_axis_tuser;         // [0] kind
  logic         m_axis_tlast;         // run_end

  // Predictor copy of the registers
  logic [1:0]         mode_q = MODE_STRIP;
  logic               wide_q = 1'b0;
  logic [FIELD_W-1:0] capacity_q = CAPACITY_RESET;
  // Predictor copy of the window and counters
  logic [31:0]        older_q = '0;
  logic [31:0]        newer_q = '0;
  phase_t             phase_q = PH_EMPTY;
  longint unsigned    written_q = 0;
  longint unsigned    received_q = 0;

  beat_t owed_beats[$];    // results predicted but not yet seen
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    send_gap_pct = 0;
  int    recv_stall_pct = 0;
  // Hand-typed summary for the beat currently on the slave side
  logic        pin_summary = 1'b0;
  logic [23:0] pin_count = '0;

  index_topology_converter_unit #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned sat_count(input longint unsigned x);
    return (x > COUNT_MAX) ? COUNT_MAX : x;
  endfunction

  // Counts wider than the output field clip at its maximum
  function automatic logic [FIELD_W-1:0] field_count(input longint unsigned x);
    return (x > FIELD_MAX) ? FIELD_MAX : x[FIELD_W-1:0];
  endfunction

  // Advance the window by one index and list the beats it produces
  function automatic void convert_index(input logic [31:0] raw, input logic last,
                                        output beat_t made[$]);
    logic [31:0] idx;
    logic [31:0] prim [3];
    int k;
    int j;
    longint unsigned sum;
    beat_t tail;
    made = {};
    k = 0;
    idx = wide_q ? raw : {16'h0000, raw[15:0]};
    received_q = sat_count(received_q + 1);

    if (phase_q == PH_EMPTY) begin
      older_q = idx;
      phase_q = PH_ONE;
    end else if (mode_q == MODE_LINE) begin
      // line strip: one segment per change of index
      if (older_q != idx) begin
        prim[0] = older_q;
        prim[1] = idx;
        k = 2;
        older_q = idx;
      end
    end else if (phase_q == PH_ONE) begin
      newer_q = idx;
      phase_q = PH_TWO;
    end else if (mode_q == MODE_STRIP) begin
      // degenerate triangles are skipped, window slides regardless
      if (older_q != newer_q && newer_q != idx) begin
        prim[0] = older_q;
        prim[1] = newer_q;
        prim[2] = idx;
        k = 3;
      end
      older_q = newer_q;
      newer_q = idx;
    end else if (mode_q == MODE_FLIP) begin
      prim[0] = older_q;
      prim[1] = idx;
      prim[2] = newer_q;
      k = 3;
      phase_q = PH_EMPTY;
    end else begin
      phase_q = PH_EMPTY;
    end

    // whole primitive only if the buffer still had room at its start
    if (k != 0 && written_q < capacity_q) begin
      for (j = 0; j < k; j++)
        made.push_back('{KIND_INDEX, prim[j], field_count(sat_count(written_q + j + 1)), 1'b0});
      written_q = sat_count(written_q + k);
    end

    if (last) begin
      sum = 0;
      if (mode_q == MODE_FLIP) sum = received_q;
      else if (mode_q != MODE_IDLE) sum = written_q;
      made.push_back('{KIND_SUMMARY, 32'h0, field_count(sum), 1'b0});
      phase_q = PH_EMPTY;
      written_q = 0;
      received_q = 0;
    end

    if (made.size() != 0) begin
      tail = made.pop_back();
      tail.run_end = 1'b1;
      made.push_back(tail);
    end
  endfunction

  // Receiver: tready redrawn every cycle at the current stall rate
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Sample every handshake at the rising edge: register writes go into the
  // predictor, slave beats add expectations, master beats are checked.
  always @(posedge clk) begin
    beat_t want;
    beat_t made[$];
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_MODE:       mode_q = cfg_data[1:0];
          REG_INDEX_WIDE: wide_q = cfg_data[0];
          REG_CAPACITY:   capacity_q = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        convert_index(s_axis_tdata, s_axis_tlast, made);
        if (pin_summary) begin
          owed_beats.push_back('{KIND_SUMMARY, 32'h0, pin_count, 1'b1});
        end else begin
          foreach (made[i]) owed_beats.push_back(made[i]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (owed_beats.size() == 0) begin
          $error("unexpected result beat: tdata %h tuser %b tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = owed_beats.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[31:0] !== want.index_out) begin
            $error("index_out: expected %h, got %h", want.index_out, m_axis_tdata[31:0]);
            mismatches++;
          end
          if (m_axis_tdata[55:32] !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, m_axis_tdata[55:32]);
            mismatches++;
          end
          if (m_axis_tlast !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, m_axis_tlast);
            mismatches++;
          end
        end
      end
      // watchdog: cycles with no beat on any channel
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // All driver tasks start and end at a falling edge.
  task automatic send_index(input logic [31:0] idx, input logic last,
                            input logic pin, input logic [23:0] pin_cnt);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = idx;
    s_axis_tlast = last;
    pin_summary = pin;
    pin_count = pin_cnt;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Hold off until every owed beat has come out, then let the queue empty
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (owed_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [23:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mix of tiny values, full-width values, repeats and high-half-only changes
  // so that degenerate primitives and 16-bit masking both get exercised.
  function automatic logic [31:0] draw_index(input logic [31:0] prev);
    case ($urandom_range(3))
      0: return 32'($urandom_range(3));
      1: return $urandom();
      2: return prev;
      default: return prev ^ 32'h0001_0000;
    endcase
  endfunction

  // Directed rows: reset defaults, field extremes, each mode, short lists,
  // trailing partial triangle, unused mode, zero capacity, and a width change
  // in the middle of a list.
  plan_row_t plan [PLAN_LEN] = '{
    // after reset: strip mode, 16-bit, full capacity; lone index -> summary 0
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hFFFF_FFFF, 1'b1, 1'b1, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h1234_5678, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hFFFF_0001, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0002, 1'b1, 1'b0, 24'd0},
    // full-width indices, one degenerate window
    '{ROW_WRITE, REG_INDEX_WIDE, 24'd1,     32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hFFFF_FFFF, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0000, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hFFFF_FFFF, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hFFFF_FFFF, 1'b1, 1'b0, 24'd0},
    // line strip with a repeated index
    '{ROW_WRITE, REG_MODE,       24'd1,     32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0007, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0007, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0009, 1'b1, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_ABCD, 1'b1, 1'b1, 24'd0},
    // flip: one triangle plus a dropped partial one
    '{ROW_WRITE, REG_MODE,       24'd2,     32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0001, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0002, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0003, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0004, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0005, 1'b1, 1'b0, 24'd0},
    // unused mode: summary reports zero
    '{ROW_WRITE, REG_MODE,       24'd3,     32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0001, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0002, 1'b1, 1'b1, 24'd0},
    // zero capacity: every primitive skipped
    '{ROW_WRITE, REG_MODE,       24'd0,     32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_WRITE, REG_CAPACITY,   24'd0,     32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0001, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0002, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'h0000_0003, 1'b1, 1'b1, 24'd0},
    // width drops to 16 bits while two wide indices sit in the window
    '{ROW_WRITE, REG_CAPACITY,   FIELD_MAX, 32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hABCD_0010, 1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hABCD_0011, 1'b0, 1'b0, 24'd0},
    '{ROW_WRITE, REG_INDEX_WIDE, 24'd0,     32'h0,         1'b0, 1'b0, 24'd0},
    '{ROW_INDEX, REG_MODE,       24'd0,     32'hABCD_0012, 1'b1, 1'b0, 24'd0}
  };

  initial begin
    int p;
    int sent;
    int len;
    int i;
    logic [1:0]  mode_pick;
    logic [23:0] cap_pick;
    logic [31:0] prev;

    // hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[r]) begin
      if (plan[r].op == ROW_WRITE)
        write_reg(plan[r].reg_sel, plan[r].reg_val);
      else
        send_index(plan[r].index, plan[r].last, plan[r].pinned, plan[r].pinned_count);
    end
    pin_summary = 1'b0;

    prev = '0;
    mode_pick = MODE_STRIP;
    for (p = 0; p < RAND_PHASES; p++) begin
      // no idling, sender gaps, receiver stalls, then both
      case (p)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 56; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 56; end
        default: begin send_gap_pct = 26; recv_stall_pct = 26; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // fresh settings at phase start and now and then between lists
        if (sent == 0 || $urandom_range(3) == 0) begin
          mode_pick = ($urandom_range(9) == 0) ? MODE_IDLE : 2'($urandom_range(2));
          case ($urandom_range(3))
            0, 1: cap_pick = FIELD_MAX;
            2: cap_pick = 24'($urandom_range(12));
            default: cap_pick = 24'($urandom());
          endcase
          write_reg(REG_MODE, {22'd0, mode_pick});
          write_reg(REG_INDEX_WIDE, 24'($urandom_range(1)));
          write_reg(REG_CAPACITY, cap_pick);
        end
        // mostly full lists; a few short ones of one or two indices
        len = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
        for (i = 0; i < len; i++) begin
          prev = draw_index(prev);
          send_index(prev, (i == len - 1), 1'b0, 24'd0);
          if (mode_pick != MODE_IDLE) sent++;
        end
      end
    end

    drain();
    if (mismatches == 0 && owed_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
